>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the utf-8 stream decoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition never holds
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_IMPLIES(lbl, clk, rst, 1'b1, !(cond), msg)

`endif

>>> rtl/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// types and constants of the utf-8 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package usd_pkg;

   localparam int CP_WIDTH = 21;

   typedef logic [CP_WIDTH-1:0] cp_type;
   typedef logic [2:0]          rcount_type;   // results of one word, 0..4

   localparam cp_type CP_REPL  = 21'h00fffd;
   localparam cp_type CP_MAX   = 21'h10ffff;
   localparam cp_type CP_MIN2  = 21'h000080;
   localparam cp_type CP_MIN3  = 21'h000800;
   localparam cp_type CP_MIN4  = 21'h010000;
   // bits 20..11 of a surrogate code point (u+d800..u+dfff)
   localparam logic [9:0] SURR_HI = 10'h01b;

   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // what one input word produces: count results, all u+fffd except the
   // final one, which carries tail
   typedef struct packed {
      rcount_type count;
      cp_type     tail;
   } rsp_desc_type;

endpackage

`default_nettype wire

>>> rtl/usd_if.sv
// ----------------------------------------------------------------------------
// usd_if
// valid/ready channels of the utf-8 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface usd_req_if import usd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface usd_rsp_if import usd_pkg::*; ();
   logic   valid;
   logic   ready;
   cp_type code_point;
   logic   last;

   modport source (output valid, output code_point, output last, input ready);
   modport sink   (input valid, input code_point, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/usd_decode.sv
// ----------------------------------------------------------------------------
// usd_decode
// input register, sequence state and per-word decode
// ----------------------------------------------------------------------------
`default_nettype none

module usd_decode import usd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic         in_op,
   input  wire logic [7:0]   in_byte,
   output      logic         in_ready,
   input  wire logic         emit_ready,
   output      logic         desc_valid,
   output      rsp_desc_type desc
);

   logic       word_valid_ff, word_valid_in;
   logic       op_ff;
   logic [7:0] byte_ff;

   logic [1:0] exp_ff, exp_in;
   logic [2:0] seen_ff, seen_in;
   cp_type     part_ff, part_in;

   logic       take;
   logic [2:0] pend;
   logic [1:0] exp_dec;
   logic [2:0] seen_inc;
   cp_type     part_ext;
   cp_type     cp_min;
   logic       cp_ok;
   logic [3:0] seq_len;

   assign take          = word_valid_ff && ((desc.count == 3'd0) || emit_ready);
   assign in_ready      = !word_valid_ff || take;
   assign desc_valid    = word_valid_ff;
   assign word_valid_in = in_ready ? in_valid : word_valid_ff;

   assign pend     = (exp_ff != 2'd0) ? seen_ff : 3'd0;
   assign exp_dec  = exp_ff - 2'd1;
   assign seen_inc = seen_ff + 3'd1;
   assign part_ext = {part_ff[CP_WIDTH-7:0], byte_ff[5:0]};

   always_comb begin
      case (seen_inc)
         3'd2:    cp_min = CP_MIN2;
         3'd3:    cp_min = CP_MIN3;
         default: cp_min = CP_MIN4;
      endcase
   end

   assign cp_ok = (part_ext <= CP_MAX) && (part_ext[20:11] != SURR_HI) &&
                  (part_ext >= cp_min);

   always_comb begin
      desc.count = 3'd0;
      desc.tail  = CP_REPL;
      exp_in     = exp_ff;
      seen_in    = seen_ff;
      part_in    = part_ff;
      if (op_ff == OP_FLUSH) begin
         desc.count = pend;
         exp_in     = 2'd0;
         seen_in    = 3'd0;
         part_in    = '0;
      end else if ((exp_ff != 2'd0) && (byte_ff[7:6] == 2'b10)) begin
         exp_in  = exp_dec;
         seen_in = seen_inc;
         part_in = part_ext;
         if (exp_dec == 2'd0) begin
            exp_in  = 2'd0;
            seen_in = 3'd0;
            part_in = '0;
            if (cp_ok) begin
               desc.count = 3'd1;
               desc.tail  = part_ext;
            end else begin
               desc.count = seen_inc;
            end
         end
      end else begin
         // any open sequence is dropped, then the byte decodes afresh
         exp_in  = 2'd0;
         seen_in = 3'd0;
         part_in = '0;
         if (byte_ff[7] == 1'b0) begin
            desc.count = pend + 3'd1;
            desc.tail  = {13'd0, byte_ff};
         end else if (byte_ff[7:5] == 3'b110) begin
            desc.count = pend;
            exp_in     = 2'd1;
            seen_in    = 3'd1;
            part_in    = {16'd0, byte_ff[4:0]};
         end else if (byte_ff[7:4] == 4'b1110) begin
            desc.count = pend;
            exp_in     = 2'd2;
            seen_in    = 3'd1;
            part_in    = {17'd0, byte_ff[3:0]};
         end else if (byte_ff[7:3] == 5'b11110) begin
            desc.count = pend;
            exp_in     = 2'd3;
            seen_in    = 3'd1;
            part_in    = {18'd0, byte_ff[2:0]};
         end else begin
            desc.count = pend + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         exp_ff        <= 2'd0;
         seen_ff       <= 3'd0;
         part_ff       <= '0;
      end else begin
         word_valid_ff <= word_valid_in;
         if (take) begin
            exp_ff  <= exp_in;
            seen_ff <= seen_in;
            part_ff <= part_in;
         end
      end
      if (in_ready) begin
         op_ff   <= in_op;
         byte_ff <= in_byte;
      end
   end

   assign seq_len = {1'b0, seen_ff} + {2'b00, exp_ff};

`include "assert_macros.svh"

   `ASSERT_NEVER(a_idle_state_clear, clock, reset, exp_ff == 2'd0 && seen_ff != 3'd0, "idle with bytes seen")
   `ASSERT_IMPLIES(a_seq_len, clock, reset, exp_ff != 2'd0, seen_ff != 3'd0 && seq_len <= 4'd4, "bad sequence length")

endmodule

`default_nettype wire

>>> rtl/usd_emit.sv
// ----------------------------------------------------------------------------
// usd_emit
// result register, plays out the results of one word one per cycle while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module usd_emit import usd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         desc_valid,
   input  wire rsp_desc_type desc,
   output      logic         emit_ready,
   output      logic         out_valid,
   input  wire logic         out_ready,
   output      cp_type       out_code_point,
   output      logic         out_last
);

   rcount_type count_ff, count_in;
   cp_type     tail_ff;
   logic       load;

   assign out_valid      = count_ff != 3'd0;
   assign out_last       = count_ff == 3'd1;
   assign out_code_point = out_last ? tail_ff : CP_REPL;

   assign emit_ready = (count_ff == 3'd0) || (out_last && out_ready);
   assign load       = desc_valid && (desc.count != 3'd0) && emit_ready;

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = desc.count;
      end else if (out_valid && out_ready) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
      if (load) begin
         tail_ff <= desc.tail;
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > 3'd4, "result count above four")
   `ASSERT_NEXT(a_count_step, clock, reset, count_ff > 3'd1 && out_ready, count_ff == $past(count_ff) - 3'd1, "result dropped or repeated")

endmodule

`default_nettype wire

>>> rtl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// utf-8 byte stream to unicode code point decoder with u+fffd replacement
//
// Each request word carries one byte (op data) or an end-of-stream flush
// (op flush). The unit answers with zero to four response words, the final
// one flagged by last. ASCII passes through, lead and continuation bytes
// build a code point that goes out when the sequence completes, and every
// malformed case (stray byte, cut-short sequence, overlong form, surrogate,
// value above u+10ffff, flush with a sequence open) gives one u+fffd per byte
// involved; a byte that interrupts a sequence is decoded afresh after the
// replacements. The request goes into an input register, is decoded there in
// one pass against the sequence state, and its results are loaded into the
// response register. Throughput is one request per cycle while the response
// side is not stalled and each request gives at most one response; a request
// giving several responses holds the response register until all are taken,
// and the next request moves in during the cycle its final response is taken.
// A request passes the input register and then the response register before
// its first response is valid. No configuration registers, no memories.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_unit import usd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   usd_req_if.sink   req_chan,
   usd_rsp_if.source rsp_chan
);

   // descriptor handoff from decode to the response register
   logic         desc_valid;
   rsp_desc_type desc;
   logic         emit_ready;

   // input register, sequence state and the decode itself
   usd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_op      (req_chan.op),
      .in_byte    (req_chan.data_byte),
      .in_ready   (req_chan.ready),
      .emit_ready (emit_ready),
      .desc_valid (desc_valid),
      .desc       (desc)
   );

   // response register, replays u+fffd then the tail code point
   usd_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .desc_valid     (desc_valid),
      .desc           (desc),
      .emit_ready     (emit_ready),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_code_point (rsp_chan.code_point),
      .out_last       (rsp_chan.last)
   );

endmodule

`default_nettype wire
